/* rtl/length_prefixed_message_ring_assert.svh */
// Assertion macros for the message ring.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH

// Same-cycle implication.
`define LPMR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lpmr_pkg.sv */
package lpmr_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int LEN_W      = 16;
    localparam int MLEN_W     = 12;
    localparam int MIN_SIZE   = 16;

    // input commands
    localparam logic [1:0] CMD_WSTART = 2'd0;
    localparam logic [1:0] CMD_WDATA  = 2'd1;
    localparam logic [1:0] CMD_RSTART = 2'd2;
    localparam logic [1:0] CMD_RNEXT  = 2'd3;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_HALF     = 3'd3;
    localparam logic [2:0] ST_NO_SPACE = 3'd4;
    localparam logic [2:0] ST_ORDER    = 3'd5;

    // open transfer
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE        = 4'd0;
    localparam logic [3:0] OP_LOAD        = 4'd1;
    localparam logic [3:0] OP_HDR_WR      = 4'd2;
    localparam logic [3:0] OP_HDR_RD      = 4'd3;
    localparam logic [3:0] OP_WSTART_FIN  = 4'd4;
    localparam logic [3:0] OP_WDATA       = 4'd5;
    localparam logic [3:0] OP_RSTART_FIN  = 4'd6;
    localparam logic [3:0] OP_RDATA_ISSUE = 4'd7;
    localparam logic [3:0] OP_RDATA_FIN   = 4'd8;
    localparam logic [3:0] OP_REJECT      = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;
        logic [2:0] code;
    } lpmr_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] mode;
        logic       half_fail;
        logic       space_fail;
        logic       empty;
        logic       too_long;
    } lpmr_stat_t;

endpackage

/* rtl/length_prefixed_message_ring.sv */
// Byte-wide ring of length-prefixed messages (4-byte little-endian prefix).
// Input stream: s_tuser carries the command (write start, write byte, read
// start, read next byte), s_tdata the length and the write byte. Every input
// transfer yields exactly one output transfer: m_tuser is the status,
// m_tdata the read byte and the stored length, m_tlast marks the final byte
// of a message and a start that opens an empty message.
// One item is in work at a time; s_tready is high only between items. The
// edge that loads the result and raises m_tvalid follows the decode step for
// a write byte or any rejected command, one registered memory read for a read
// byte, and the four prefix bytes through the single write port or the single
// read port for a write start or a read start (a read start also waits for
// its last prefix byte to shift in). s_tready rises again at that edge.
// A result waiting on m_tready does not block the next accept; the next
// item then holds at its final step until the output register drains.
// cfg_data sets ring_size (clamped to 16..4096) and empties the ring; write
// it only while no item is open. Reset empties the ring and sets size 4096.
module length_prefixed_message_ring
    import lpmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // length[15:0], data_in[23:16]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_out[7:0], msg_length[19:8], zero[23:20]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // ring_size
);

    lpmr_cmd_t         dp_cmd;
    lpmr_stat_t        dp_stat;
    logic [2:0]        status;
    logic [7:0]        data_out;
    logic [MLEN_W-1:0] msg_length;
    logic              last;
    logic              cfg_we;
    logic              out_fail;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    lpmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    lpmr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .in_cmd     (s_tuser),
        .in_length  (s_tdata[15:0]),
        .in_data    (s_tdata[23:16]),
        .cfg_we     (cfg_we),
        .cfg_size   (cfg_data),
        .status     (status),
        .data_out   (data_out),
        .msg_length (msg_length),
        .last       (last)
    );

    assign m_tdata = {4'b0, msg_length, data_out};
    assign m_tuser = status;
    assign m_tlast = last;

    assign out_fail = m_tuser != ST_OK && m_tuser != ST_TOO_LONG;

`include "length_prefixed_message_ring_assert.svh"

    `LPMR_ASSERT_NOW(a_last_ok, m_tvalid && m_tlast, m_tuser == ST_OK, "last on failed item")
    `LPMR_ASSERT_NOW(a_fail_zero, m_tvalid && out_fail, m_tdata == '0, "payload on failed item")
    `LPMR_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `LPMR_ASSERT_NEXT(a_cfg_idle, cfg_we, dp_stat.mode == MODE_IDLE, "open after resize")

endmodule

/* rtl/lpmr_datapath.sv */
module lpmr_datapath
    import lpmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lpmr_cmd_t         cmd,
    output lpmr_stat_t        stat,
    input  logic [1:0]        in_cmd,
    input  logic [LEN_W-1:0]  in_length,
    input  logic [7:0]        in_data,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_size,
    output logic [2:0]        status,
    output logic [7:0]        data_out,
    output logic [MLEN_W-1:0] msg_length,
    output logic              last
);

    logic [7:0] ring_mem [RING_DEPTH];

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] rp_reg, rp_next, wp_reg, wp_next;
    logic [ADDR_W-1:0] pwp_reg, pwp_next, prp_reg, prp_next;
    logic [ADDR_W-1:0] tmp_reg, tmp_next;
    logic [MLEN_W-1:0] brw_reg, brw_next, brr_reg, brr_next;
    logic [1:0]        mode_reg, mode_next;
    logic              hdr_pend_reg, hdr_pend_next;
    logic [1:0]        cmd_in_reg, cmd_in_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [7:0]        din_reg, din_next;
    logic [31:0]       stored_reg, stored_next;
    logic [7:0]        rdata_reg;
    logic [2:0]        status_reg, status_next;
    logic [7:0]        dout_reg, dout_next;
    logic [MLEN_W-1:0] mlen_reg, mlen_next;
    logic              last_reg, last_next;

    logic              mem_we, rd_en;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        wdata;
    logic [SIZE_W-1:0] sz, avail;
    logic [ADDR_W-1:0] adv_tmp, adv_pwp, adv_prp;

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] n;
        n = {1'b0, p} + SIZE_W'(1);
        return (n >= lim) ? '0 : n[ADDR_W-1:0];
    endfunction

    // size register used clamped to the supported range
    always_comb
    begin
        if (size_reg < SIZE_W'(MIN_SIZE))
            sz = SIZE_W'(MIN_SIZE);
        else if (size_reg > SIZE_W'(RING_DEPTH))
            sz = SIZE_W'(RING_DEPTH);
        else
            sz = size_reg;
    end

    always_comb
    begin
        if (wp_reg >= rp_reg)
            avail = sz - {1'b0, wp_reg - rp_reg};
        else
            avail = {1'b0, rp_reg - wp_reg};
    end

    assign adv_tmp = advance(tmp_reg, sz);
    assign adv_pwp = advance(pwp_reg, sz);
    assign adv_prp = advance(prp_reg, sz);

    assign stat.cmd        = cmd_in_reg;
    assign stat.mode       = mode_reg;
    assign stat.half_fail  = len_reg > {4'b0, sz[SIZE_W-1:1]};
    assign stat.space_fail = {4'b0, avail} <= ({1'b0, len_reg} + 17'd5);
    assign stat.empty      = rp_reg == wp_reg;
    assign stat.too_long   = stored_reg > {16'b0, len_reg};

    always_comb
    begin
        size_next     = size_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        pwp_next      = pwp_reg;
        prp_next      = prp_reg;
        tmp_next      = tmp_reg;
        brw_next      = brw_reg;
        brr_next      = brr_reg;
        mode_next     = mode_reg;
        hdr_pend_next = 1'b0;
        cmd_in_next   = cmd_in_reg;
        len_next      = len_reg;
        din_next      = din_reg;
        stored_next   = hdr_pend_reg ? {rdata_reg, stored_reg[31:8]} : stored_reg;
        status_next   = status_reg;
        dout_next     = dout_reg;
        mlen_next     = mlen_reg;
        last_next     = last_reg;
        mem_we        = 1'b0;
        waddr         = tmp_reg;
        wdata         = 8'd0;
        rd_en         = 1'b0;
        raddr         = tmp_reg;

        // every result-producing op starts from a clean result
        if (cmd.op == OP_WSTART_FIN || cmd.op == OP_WDATA || cmd.op == OP_RSTART_FIN ||
            cmd.op == OP_RDATA_FIN || cmd.op == OP_REJECT)
        begin
            status_next = ST_OK;
            dout_next   = 8'd0;
            mlen_next   = '0;
            last_next   = 1'b0;
        end

        case (cmd.op)
            OP_LOAD:
            begin
                cmd_in_next = in_cmd;
                len_next    = in_length;
                din_next    = in_data;
                tmp_next    = (in_cmd == CMD_RSTART) ? rp_reg : wp_reg;
            end
            OP_HDR_WR:
            begin
                mem_we   = 1'b1;
                waddr    = tmp_reg;
                case (cmd.idx)
                    2'd0:    wdata = len_reg[7:0];
                    2'd1:    wdata = len_reg[15:8];
                    default: wdata = 8'd0;
                endcase
                tmp_next = adv_tmp;
            end
            OP_HDR_RD:
            begin
                rd_en         = 1'b1;
                raddr         = tmp_reg;
                tmp_next      = adv_tmp;
                hdr_pend_next = 1'b1;
            end
            OP_WSTART_FIN:
            begin
                pwp_next = tmp_reg;
                brw_next = len_reg[MLEN_W-1:0];
                if (len_reg == '0)
                begin
                    wp_next   = tmp_reg;
                    last_next = 1'b1;
                end
                else
                    mode_next = MODE_WRITE;
            end
            OP_WDATA:
            begin
                mem_we   = 1'b1;
                waddr    = pwp_reg;
                wdata    = din_reg;
                pwp_next = adv_pwp;
                brw_next = brw_reg - MLEN_W'(1);
                if (brw_reg == MLEN_W'(1))
                begin
                    wp_next   = adv_pwp;
                    mode_next = MODE_IDLE;
                    last_next = 1'b1;
                end
            end
            OP_RSTART_FIN:
            begin
                mlen_next = stored_reg[MLEN_W-1:0];
                if (stat.too_long)
                    status_next = ST_TOO_LONG;
                else
                begin
                    prp_next = tmp_reg;
                    brr_next = stored_reg[MLEN_W-1:0];
                    if (stored_reg[MLEN_W-1:0] == '0)
                    begin
                        rp_next   = tmp_reg;
                        last_next = 1'b1;
                    end
                    else
                        mode_next = MODE_READ;
                end
            end
            OP_RDATA_ISSUE:
            begin
                rd_en = 1'b1;
                raddr = prp_reg;
            end
            OP_RDATA_FIN:
            begin
                dout_next = rdata_reg;
                prp_next  = adv_prp;
                brr_next  = brr_reg - MLEN_W'(1);
                if (brr_reg == MLEN_W'(1))
                begin
                    rp_next   = adv_prp;
                    mode_next = MODE_IDLE;
                    last_next = 1'b1;
                end
            end
            OP_REJECT:
            begin
                status_next = cmd.code;
            end
            default:
            begin
            end
        endcase

        // a size change empties the ring
        if (cfg_we)
        begin
            size_next = cfg_size;
            rp_next   = '0;
            wp_next   = '0;
            pwp_next  = '0;
            prp_next  = '0;
            brw_next  = '0;
            brr_next  = '0;
            mode_next = MODE_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SIZE_W'(RING_DEPTH);
            rp_reg       <= '0;
            wp_reg       <= '0;
            pwp_reg      <= '0;
            prp_reg      <= '0;
            brw_reg      <= '0;
            brr_reg      <= '0;
            mode_reg     <= MODE_IDLE;
            hdr_pend_reg <= 1'b0;
        end
        else
        begin
            size_reg     <= size_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            pwp_reg      <= pwp_next;
            prp_reg      <= prp_next;
            brw_reg      <= brw_next;
            brr_reg      <= brr_next;
            mode_reg     <= mode_next;
            hdr_pend_reg <= hdr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_in_reg <= cmd_in_next;
        len_reg    <= len_next;
        din_reg    <= din_next;
        tmp_reg    <= tmp_next;
        stored_reg <= stored_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
        mlen_reg   <= mlen_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= ring_mem[raddr];
    end

    assign status     = status_reg;
    assign data_out   = dout_reg;
    assign msg_length = mlen_reg;
    assign last       = last_reg;

endmodule

/* rtl/lpmr_ctrl.sv */
module lpmr_ctrl
    import lpmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  lpmr_stat_t stat,
    output lpmr_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_WHDR  = 3'd2;
    localparam logic [2:0] S_WFIN  = 3'd3;
    localparam logic [2:0] S_RHDR  = 3'd4;
    localparam logic [2:0] S_RWAIT = 3'd5;
    localparam logic [2:0] S_RFIN  = 3'd6;
    localparam logic [2:0] S_RDAT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_emit, emit, rej;
    logic [2:0] rej_code;

    // the output register is free now or drains this cycle
    assign can_emit = !out_valid_reg || m_tready;

    always_comb
    begin
        rej      = 1'b0;
        rej_code = ST_ORDER;
        case (stat.cmd)
            CMD_WSTART:
            begin
                if (stat.mode != MODE_IDLE)
                    rej = 1'b1;
                else if (stat.half_fail)
                begin
                    rej      = 1'b1;
                    rej_code = ST_HALF;
                end
                else if (stat.space_fail)
                begin
                    rej      = 1'b1;
                    rej_code = ST_NO_SPACE;
                end
            end
            CMD_WDATA:  rej = stat.mode != MODE_WRITE;
            CMD_RSTART:
            begin
                if (stat.mode != MODE_IDLE)
                    rej = 1'b1;
                else if (stat.empty)
                begin
                    rej      = 1'b1;
                    rej_code = ST_EMPTY;
                end
            end
            CMD_RNEXT:  rej = stat.mode != MODE_READ;
            default:    rej = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg;
        cmd.code   = rej_code;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cnt_next = 2'd0;
                if (rej)
                begin
                    if (can_emit)
                    begin
                        cmd.op     = OP_REJECT;
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    case (stat.cmd)
                        CMD_WSTART: state_next = S_WHDR;
                        CMD_WDATA:
                        begin
                            if (can_emit)
                            begin
                                cmd.op     = OP_WDATA;
                                emit       = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        CMD_RSTART: state_next = S_RHDR;
                        default:
                        begin
                            cmd.op     = OP_RDATA_ISSUE;
                            state_next = S_RDAT;
                        end
                    endcase
                end
            end
            S_WHDR:
            begin
                cmd.op   = OP_HDR_WR;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_WFIN;
            end
            S_WFIN:
            begin
                if (can_emit)
                begin
                    cmd.op     = OP_WSTART_FIN;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RHDR:
            begin
                cmd.op   = OP_HDR_RD;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                // last prefix byte shifts in
                state_next = S_RFIN;
            end
            S_RFIN:
            begin
                if (can_emit)
                begin
                    cmd.op     = OP_RSTART_FIN;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDAT:
            begin
                if (can_emit)
                begin
                    cmd.op     = OP_RDATA_FIN;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

/* sim/length_prefixed_message_ring_test.sv */
`timescale 1ns / 100ps

module length_prefixed_message_ring_test
    import lpmr_pkg::*;
();

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data;
        logic [11:0] mlen;
        logic        last;
    } ring_reply_t;

    // Shadow copy of the ring: replays every accepted command and keeps the
    // replies the block owes us, oldest first.
    class message_ring_shadow;
        logic [7:0]  ring_mem [RING_DEPTH];
        int unsigned size_eff;
        int unsigned rd_pos;
        int unsigned wr_pos;
        int unsigned wr_pend;
        int unsigned rd_pend;
        int unsigned wr_left;
        int unsigned rd_left;
        logic [1:0]  mode;
        ring_reply_t pending_replies[$];
        int          errors;

        function void set_size(logic [12:0] v);
            if (v < MIN_SIZE)
                size_eff = MIN_SIZE;
            else if (v > RING_DEPTH)
                size_eff = RING_DEPTH;
            else
                size_eff = 32'(v);
            rd_pos = 0;
            wr_pos = 0;
            wr_pend = 0;
            rd_pend = 0;
            wr_left = 0;
            rd_left = 0;
            mode = MODE_IDLE;
        endfunction

        function int unsigned wrap_next(int unsigned p);
            return (p + 1 >= size_eff) ? 0 : p + 1;
        endfunction

        function void take_command(logic [1:0] cmd, logic [15:0] len, logic [7:0] din);
            ring_reply_t r;
            int unsigned p;
            int unsigned stored;
            int unsigned avail;
            r = '0;
            case (cmd)
                CMD_WSTART:
                begin
                    if (mode != MODE_IDLE)
                        r.status = ST_ORDER;
                    else if (len > size_eff / 2)
                        r.status = ST_HALF;
                    else
                    begin
                        if (wr_pos >= rd_pos)
                            avail = size_eff - (wr_pos - rd_pos);
                        else
                            avail = rd_pos - wr_pos;
                        if (avail <= int'(len) + 5)
                            r.status = ST_NO_SPACE;
                        else
                        begin
                            p = wr_pos;
                            for (int i = 0; i < 4; i++)
                            begin
                                ring_mem[p] = 8'(int'(len) >> (8 * i));
                                p = wrap_next(p);
                            end
                            wr_pend = p;
                            wr_left = 32'(len);
                            if (len == 0)
                            begin
                                wr_pos = p;
                                r.last = 1'b1;
                            end
                            else
                                mode = MODE_WRITE;
                        end
                    end
                end
                CMD_WDATA:
                begin
                    if (mode != MODE_WRITE)
                        r.status = ST_ORDER;
                    else
                    begin
                        ring_mem[wr_pend] = din;
                        wr_pend = wrap_next(wr_pend);
                        wr_left--;
                        if (wr_left == 0)
                        begin
                            wr_pos = wr_pend;
                            mode = MODE_IDLE;
                            r.last = 1'b1;
                        end
                    end
                end
                CMD_RSTART:
                begin
                    if (mode != MODE_IDLE)
                        r.status = ST_ORDER;
                    else if (rd_pos == wr_pos)
                        r.status = ST_EMPTY;
                    else
                    begin
                        p = rd_pos;
                        stored = 0;
                        for (int i = 0; i < 4; i++)
                        begin
                            stored |= 32'(ring_mem[p]) << (8 * i);
                            p = wrap_next(p);
                        end
                        r.mlen = stored[11:0];
                        if (stored > len)
                            r.status = ST_TOO_LONG;
                        else
                        begin
                            rd_pend = p;
                            rd_left = 32'(stored[11:0]);
                            if (rd_left == 0)
                            begin
                                rd_pos = p;
                                r.last = 1'b1;
                            end
                            else
                                mode = MODE_READ;
                        end
                    end
                end
                default:
                begin
                    if (mode != MODE_READ)
                        r.status = ST_ORDER;
                    else
                    begin
                        r.data = ring_mem[rd_pend];
                        rd_pend = wrap_next(rd_pend);
                        rd_left--;
                        if (rd_left == 0)
                        begin
                            rd_pos = rd_pend;
                            mode = MODE_IDLE;
                            r.last = 1'b1;
                        end
                    end
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        function void match_reply(logic [2:0] st, logic [7:0] d, logic [11:0] ml, logic lt);
            ring_reply_t e;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: status %0d data %02h len %0d last %0d",
                             st, d, ml, lt);
                return;
            end
            e = pending_replies.pop_front();
            if (e.status !== st || e.data !== d || e.mlen !== ml || e.last !== lt)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp status %0d data %02h len %0d last %0d, ",
                              "got status %0d data %02h len %0d last %0d"},
                             e.status, e.data, e.mlen, e.last, st, d, ml, lt);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // length[15:0], data_in[23:16]
    logic [1:0]  s_tuser = '0;     // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // data_out[7:0], msg_length[19:8], zero[23:20]
    logic [2:0]  m_tuser;          // status[2:0]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;    // ring_size

    message_ring_shadow sb;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned tick = 0;

    length_prefixed_message_ring i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: switches between stall patterns
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        tick++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (tick % 5) < 3;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.match_reply(m_tuser, m_tdata[7:0], m_tdata[19:8], m_tlast);
    end

    task automatic put_item(input logic [1:0] cmd, input logic [15:0] len, input logic [7:0] din);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {din, len};
        do @(posedge clk); while (!s_tready);
        sb.take_command(cmd, len, din);
    endtask

    task automatic wait_replies;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_ring_size(input logic [12:0] v);
        // finish any open message so the block is fully idle
        while (sb.mode == MODE_WRITE)
            put_item(CMD_WDATA, 16'($urandom), 8'($urandom));
        while (sb.mode == MODE_READ)
            put_item(CMD_RNEXT, 16'($urandom), 8'($urandom));
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait_replies();
        repeat (12) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_size(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        logic [1:0]  cmd;
        logic [15:0] len;
        logic [7:0]  din;
        int unsigned half;
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            half = sb.size_eff / 2;
            len = 16'($urandom);
            din = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (sb.mode == MODE_WRITE)
                cmd = (pick < 6) ? 2'($urandom_range(0, 3)) : CMD_WDATA;
            else if (sb.mode == MODE_READ)
                cmd = (pick < 6) ? 2'($urandom_range(0, 3)) : CMD_RNEXT;
            else if (pick < 4)
                cmd = $urandom_range(0, 1) ? CMD_WDATA : CMD_RNEXT;
            else if (pick < 52)
            begin
                cmd = CMD_WSTART;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, (half < 12) ? half : 12));
                    6: len = 16'($urandom_range(0, (half < 200) ? half : 200));
                    // exactly half only on small rings to keep messages short
                    7: len = 16'((half > 64) ? half + 1 : half + $urandom_range(0, 1));
                    8: ;
                    default: len = 16'd0;
                endcase
            end
            else
            begin
                cmd = CMD_RSTART;
                len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16)) : 16'hFFFF;
            end
            put_item(cmd, len, din);
        end
    endtask

    initial
    begin
        sb = new;
        sb.set_size(13'd4096);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty ring, out-of-order commands, zero-length and over-half starts
        put_item(CMD_RSTART, 16'hFFFF, 8'h00);
        put_item(CMD_WDATA, 16'h0000, 8'h5A);
        put_item(CMD_RNEXT, 16'h0000, 8'h00);
        put_item(CMD_WSTART, 16'd0, 8'h00);
        put_item(CMD_WSTART, 16'hFFFF, 8'hFF);
        put_item(CMD_WSTART, 16'd2049, 8'h00);
        put_item(CMD_WSTART, 16'd3, 8'h00);
        put_item(CMD_WSTART, 16'd1, 8'h00);
        put_item(CMD_RSTART, 16'hFFFF, 8'h00);
        put_item(CMD_RNEXT, 16'h0000, 8'h00);
        put_item(CMD_WDATA, 16'hFFFF, 8'h00);
        put_item(CMD_WDATA, 16'h0000, 8'hFF);
        put_item(CMD_WDATA, 16'h1234, 8'hA5);
        put_item(CMD_RSTART, 16'd0, 8'h00);
        put_item(CMD_RSTART, 16'd2, 8'h00);
        put_item(CMD_RSTART, 16'hFFFF, 8'h00);
        put_item(CMD_WSTART, 16'd0, 8'h00);
        put_item(CMD_WDATA, 16'd0, 8'h11);
        put_item(CMD_RSTART, 16'hFFFF, 8'h00);
        put_item(CMD_RNEXT, 16'd0, 8'h00);
        put_item(CMD_RNEXT, 16'd0, 8'h00);
        put_item(CMD_RNEXT, 16'd0, 8'h00);
        put_item(CMD_RSTART, 16'hFFFF, 8'h00);

        // smallest ring: half and no-space limits are hit quickly
        apply_ring_size(13'd16);
        put_item(CMD_WSTART, 16'd9, 8'h00);
        put_item(CMD_WSTART, 16'd8, 8'h00);
        random_traffic(60);

        apply_ring_size(13'd0);
        random_traffic(40);

        apply_ring_size(13'h1FFF);
        random_traffic(60);

        apply_ring_size(13'($urandom_range(17, 200)));
        random_traffic(80);

        apply_ring_size(13'($urandom_range(16, 4096)));
        random_traffic(90);

        // full ring: largest message for this size, reader limit one short, then read back
        apply_ring_size(13'd64);
        put_item(CMD_WSTART, 16'd32, 8'h00);
        repeat (32) put_item(CMD_WDATA, 16'($urandom), 8'($urandom));
        put_item(CMD_WSTART, 16'd32, 8'h00);
        put_item(CMD_RSTART, 16'd31, 8'h00);
        put_item(CMD_RSTART, 16'd32, 8'h00);
        repeat (32) put_item(CMD_RNEXT, 16'($urandom), 8'($urandom));
        random_traffic(40);

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_replies();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lpmr_pkg.sv
rtl/lpmr_datapath.sv
rtl/lpmr_ctrl.sv
rtl/length_prefixed_message_ring.sv
sim/length_prefixed_message_ring_test.sv
